[rtl/cic_pkg.sv]
package cic_pkg;

    // Data formats
    localparam int DATA_W    = 32;  // Q16.16 sample, state and gain width
    localparam int POLE_W    = 18;  // pole coefficient width
    localparam int PROD_W    = 2 * DATA_W;
    localparam int FRAC_W    = 16;
    localparam int RND_W     = PROD_W - FRAC_W;
    localparam int ACC_W     = RND_W + 2;
    localparam int NUM_STEPS = 18;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam int IDX_W     = 3;

    typedef logic [STEP_W-1:0] step_t;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_FFG = 3'd0,
        REG_IG  = 3'd1,
        REG_FSG = 3'd2,
        REG_OG  = 3'd3,
        REG_FZC = 3'd4,
        REG_FPC = 3'd5,
        REG_SPC = 3'd6,
        REG_IPC = 3'd7
    } reg_idx_t;

    // Coefficient set handed to the datapath
    typedef struct packed {
        logic [DATA_W-1:0] ffg;
        logic [DATA_W-1:0] ig;
        logic [DATA_W-1:0] fsg;
        logic [DATA_W-1:0] og;
        logic [DATA_W-1:0] fzc;
        logic [POLE_W-1:0] fpc;
        logic [POLE_W-1:0] spc;
        logic [POLE_W-1:0] ipc;
    } cfg_t;

    // Step wait conditions
    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN,
        COND_OUT
    } cond_t;

    // Multiplier coefficient operand
    typedef enum logic [2:0] {
        MA_FFG,
        MA_IG,
        MA_FSG,
        MA_OG,
        MA_FZC,
        MA_FPC,
        MA_SPC,
        MA_IPC
    } mul_a_t;

    // Multiplier data operand
    typedef enum logic [2:0] {
        MB_X,
        MB_IPO,
        MB_FPI,
        MB_FPO,
        MB_SPO,
        MB_SAT
    } mul_b_t;

    // Accumulator base term
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_ACC,
        BASE_SAT
    } base_t;

    // Accumulator addend term
    typedef enum logic [2:0] {
        ADD_NONE,
        ADD_RND,
        ADD_X,
        SUB_IPI,
        ADD_SPI
    } addend_t;

    // Write strobes for the saturated accumulator value
    typedef struct packed {
        logic ipi;    // injection previous input takes x
        logic ipo;
        logic fpi;
        logic fpo;
        logic spi;
        logic spo;
        logic drive;
    } wmask_t;

    // One microcode control word
    typedef struct packed {
        cond_t   cond;
        logic    load_x;
        logic    mul_en;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        base_t   base;
        addend_t addend;
        wmask_t  wr;
        logic    last;
    } uop_t;

endpackage

[rtl/cic_ucode_rom.sv]
module cic_ucode_rom (
    input  cic_pkg::step_t step,
    output cic_pkg::uop_t  uop
);
    import cic_pkg::*;

    // Program: a multiply passes the product register, then the rounded register
    always_comb
    begin
        uop        = '0;
        uop.cond   = COND_NONE;
        uop.mul_a  = MA_FFG;
        uop.mul_b  = MB_X;
        uop.base   = BASE_ACC;
        uop.addend = ADD_NONE;
        case (step)
            5'd0:
            begin
                uop.cond   = COND_IN;
                uop.load_x = 1'b1;
            end
            5'd1:
            begin
                uop.mul_en = 1'b1;
                uop.mul_a  = MA_IPC;
                uop.mul_b  = MB_IPO;
                uop.base   = BASE_ZERO;
                uop.addend = ADD_X;
            end
            5'd2:
            begin
                uop.mul_en = 1'b1;
                uop.mul_a  = MA_FFG;
                uop.mul_b  = MB_X;
                uop.addend = SUB_IPI;
            end
            5'd3:
            begin
                uop.addend = ADD_RND;
            end
            5'd4:
            begin
                // v is ready: store it and scale it by the injection gain
                uop.mul_en = 1'b1;
                uop.mul_a  = MA_IG;
                uop.mul_b  = MB_SAT;
                uop.wr.ipo = 1'b1;
                uop.wr.ipi = 1'b1;
                uop.base   = BASE_ZERO;
                uop.addend = ADD_RND;
            end
            5'd5:
            begin
                uop.mul_en = 1'b1;
                uop.mul_a  = MA_FZC;
                uop.mul_b  = MB_FPI;
            end
            5'd6:
            begin
                uop.mul_en = 1'b1;
                uop.mul_a  = MA_FPC;
                uop.mul_b  = MB_FPO;
                uop.addend = ADD_RND;
            end
            5'd7:
            begin
                // s1 is ready
                uop.wr.fpi = 1'b1;
                uop.base   = BASE_SAT;
                uop.addend = ADD_RND;
            end
            5'd8:
            begin
                uop.addend = ADD_RND;
            end
            5'd9:
            begin
                // w is ready
                uop.mul_en = 1'b1;
                uop.mul_a  = MA_FSG;
                uop.mul_b  = MB_SAT;
                uop.wr.fpo = 1'b1;
            end
            5'd10:
            begin
                uop.mul_en = 1'b1;
                uop.mul_a  = MA_SPC;
                uop.mul_b  = MB_SPO;
            end
            5'd11:
            begin
                uop.base   = BASE_ZERO;
                uop.addend = ADD_RND;
            end
            5'd12:
            begin
                // s2 is ready
                uop.wr.spi = 1'b1;
                uop.base   = BASE_SAT;
                uop.addend = ADD_SPI;
            end
            5'd13:
            begin
                uop.addend = ADD_RND;
            end
            5'd14:
            begin
                // u is ready
                uop.mul_en = 1'b1;
                uop.mul_a  = MA_OG;
                uop.mul_b  = MB_SAT;
                uop.wr.spo = 1'b1;
            end
            5'd15:
            begin
                uop.base = BASE_ACC;
            end
            5'd16:
            begin
                uop.base   = BASE_ZERO;
                uop.addend = ADD_RND;
            end
            5'd17:
            begin
                uop.cond     = COND_OUT;
                uop.wr.drive = 1'b1;
                uop.last     = 1'b1;
            end
            default:
            begin
                uop.last = 1'b1;
            end
        endcase
    end

endmodule

[rtl/cic_datapath.sv]
module cic_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cic_pkg::uop_t               uop,
    input  logic                        fire,
    input  logic [cic_pkg::DATA_W-1:0]  sample,
    input  cic_pkg::cfg_t               cfg,
    output logic [cic_pkg::DATA_W-1:0]  sat_acc
);
    import cic_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (FRAC_W - 1);

    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] ipi_reg, ipo_reg, fpi_reg, fpo_reg, spi_reg, spo_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [RND_W-1:0]  rnd_reg, rnd_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_rounded;
    logic signed [DATA_W-1:0] op_a, op_b;
    logic signed [ACC_W-1:0]  base_val, add_val;
    logic                     acc_in_range;

    // Saturate the accumulator to the 32-bit range
    always_comb
    begin
        acc_in_range = (acc_reg[ACC_W-1:DATA_W-1] == '0) ||
                       (acc_reg[ACC_W-1:DATA_W-1] == '1);
        if (acc_in_range)
            sat_acc = acc_reg[DATA_W-1:0];
        else if (acc_reg[ACC_W-1])
            sat_acc = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat_acc = {1'b0, {(DATA_W-1){1'b1}}};
    end

    // Select multiplier operands
    always_comb
    begin
        case (uop.mul_a)
            MA_FFG:  op_a = $signed(cfg.ffg);
            MA_IG:   op_a = $signed(cfg.ig);
            MA_FSG:  op_a = $signed(cfg.fsg);
            MA_OG:   op_a = $signed(cfg.og);
            MA_FZC:  op_a = $signed(cfg.fzc);
            MA_FPC:  op_a = DATA_W'($signed(cfg.fpc));
            MA_SPC:  op_a = DATA_W'($signed(cfg.spc));
            MA_IPC:  op_a = DATA_W'($signed(cfg.ipc));
            default: op_a = '0;
        endcase
        case (uop.mul_b)
            MB_X:    op_b = $signed(x_reg);
            MB_IPO:  op_b = $signed(ipo_reg);
            MB_FPI:  op_b = $signed(fpi_reg);
            MB_FPO:  op_b = $signed(fpo_reg);
            MB_SPO:  op_b = $signed(spo_reg);
            MB_SAT:  op_b = $signed(sat_acc);
            default: op_b = '0;
        endcase
    end

    // Multiply, then round to Q16.16 with ties toward plus infinity
    always_comb
    begin
        prod_next    = (fire && uop.mul_en) ? op_a * op_b : prod_reg;
        prod_rounded = prod_reg + HALF_LSB;
        rnd_next     = prod_rounded[PROD_W-1:FRAC_W];
    end

    // Accumulate base plus addend
    always_comb
    begin
        case (uop.base)
            BASE_ZERO: base_val = '0;
            BASE_ACC:  base_val = acc_reg;
            BASE_SAT:  base_val = ACC_W'($signed(sat_acc));
            default:   base_val = acc_reg;
        endcase
        case (uop.addend)
            ADD_NONE: add_val = '0;
            ADD_RND:  add_val = ACC_W'(rnd_reg);
            ADD_X:    add_val = ACC_W'($signed(x_reg));
            SUB_IPI:  add_val = -ACC_W'($signed(ipi_reg));
            ADD_SPI:  add_val = ACC_W'($signed(spi_reg));
            default:  add_val = '0;
        endcase
        acc_next = base_val + add_val;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
        if (fire)
            acc_reg <= acc_next;
        if (fire && uop.load_x)
            x_reg <= sample;
    end

    // Section history, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipi_reg <= '0;
            ipo_reg <= '0;
            fpi_reg <= '0;
            fpo_reg <= '0;
            spi_reg <= '0;
            spo_reg <= '0;
        end
        else if (fire)
        begin
            if (uop.wr.ipi)
                ipi_reg <= x_reg;
            if (uop.wr.ipo)
                ipo_reg <= sat_acc;
            if (uop.wr.fpi)
                fpi_reg <= sat_acc;
            if (uop.wr.fpo)
                fpo_reg <= sat_acc;
            if (uop.wr.spi)
                spi_reg <= sat_acc;
            if (uop.wr.spo)
                spo_reg <= sat_acc;
        end
    end

    // The injection output history write carries the saturated value, never a raw sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && uop.wr.ipo) |=> ($signed(ipo_reg) == $signed($past(sat_acc))))
        else $error("injection history not loaded from saturated accumulator");

    // Compare at full product width
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && uop.mul_en) |=> (prod_reg == $past(op_a) * $past(op_b)))
        else $error("product register missed an issued multiply");

    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(acc_reg))
        else $error("accumulator moved while the step was held");

endmodule

[rtl/cascaded_iir_compensator.sv]
// Cascaded first-order IIR compensator (injection, lead and lag sections).
// Input channel: in_valid / in_stall / sample carries one Q16.16 error word.
// Output channel: out_valid / out_stall / drive carries one Q16.16 word per
// input word, saturated to the signed 32-bit range.
// Coefficients are written through wr_en / wr_index / wr_data; the user
// must write them only while idle, as the block does not enforce it. Pole
// coefficients use the low 18 bits of wr_data, sign-extended. A small
// microcode program of 18 steps runs one shared 32x32 multiplier and one
// accumulator. A new input word is taken only after the program is through
// with the last one, as the eight dependent multiplies share the single
// multiplier and its product and rounded registers.
// in_stall is low only on the program's first step.
// The output register frees the datapath: the next input word is taken
// while a finished drive word still waits. If the receiver stalls, the
// program holds on its last step until the output register is free.
// Reset clears all coefficients, section history and the output valid.
module cascaded_iir_compensator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [cic_pkg::IDX_W-1:0]       wr_index,
    input  logic [cic_pkg::DATA_W-1:0]      wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [cic_pkg::DATA_W-1:0] sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [cic_pkg::DATA_W-1:0] drive
);
    import cic_pkg::*;

    step_t             step_reg, step_next;
    uop_t              uop;
    cfg_t              cfg_reg;
    logic              fire;
    logic [DATA_W-1:0] sat_acc;
    logic [DATA_W-1:0] drive_reg;
    logic              out_valid_reg, out_valid_next;

    cic_ucode_rom u_rom (
        .step (step_reg),
        .uop  (uop)
    );

    cic_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .uop     (uop),
        .fire    (fire),
        .sample  (sample),
        .cfg     (cfg_reg),
        .sat_acc (sat_acc)
    );

    // Step condition and next step
    always_comb
    begin
        case (uop.cond)
            COND_NONE: fire = 1'b1;
            COND_IN:   fire = in_valid;
            COND_OUT:  fire = !out_valid_reg || !out_stall;
            default:   fire = 1'b1;
        endcase
        if (!fire)
            step_next = step_reg;
        else if (uop.last)
            step_next = '0;
        else
            step_next = step_reg + step_t'(1);
    end

    assign in_stall = (uop.cond != COND_IN);

    // Output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (fire && uop.wr.drive)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (fire && uop.wr.drive)
            drive_reg <= sat_acc;
    end

    assign out_valid = out_valid_reg;
    assign drive     = $signed(drive_reg);

    // Sequencer and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                case (reg_idx_t'(wr_index))
                    REG_FFG: cfg_reg.ffg <= wr_data;
                    REG_IG:  cfg_reg.ig  <= wr_data;
                    REG_FSG: cfg_reg.fsg <= wr_data;
                    REG_OG:  cfg_reg.og  <= wr_data;
                    REG_FZC: cfg_reg.fzc <= wr_data;
                    REG_FPC: cfg_reg.fpc <= wr_data[POLE_W-1:0];
                    REG_SPC: cfg_reg.spc <= wr_data[POLE_W-1:0];
                    REG_IPC: cfg_reg.ipc <= wr_data[POLE_W-1:0];
                    default: cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    // The step counter never leaves the program
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < step_t'(NUM_STEPS))
        else $error("step counter outside program");

    // A waiting drive word is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && uop.wr.drive) |-> !fire)
        else $error("drive word overwritten while stalled");

    // After the last step the program returns to the input wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && uop.last) |=> (step_reg == '0 && uop.cond == COND_IN))
        else $error("program did not return to the input step");

    // An input word is taken only on the program's first step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (step_reg == step_t'(1)))
        else $error("input word taken outside the first step");

endmodule

[sim/testbench.sv]
module testbench;
    import cic_pkg::*;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    // One line of the directed script: a sample word or a register write
    typedef struct packed {
        row_kind_t         kind;
        reg_idx_t          idx;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic [DATA_W-1:0] want;
    } row_t;

    typedef enum {
        SET_TAME,
        SET_WILD,
        SET_EXTREME
    } coef_style_t;

    logic                     clk;
    logic                     rst_n;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_index;
    logic [DATA_W-1:0]        wr_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] sample;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] drive;

    // Predictor copy of the coefficients and the section history
    longint coef [8];
    longint inj_in_h   = 0;
    longint inj_out_h  = 0;
    longint lead_in_h  = 0;
    longint lead_out_h = 0;
    longint lag_in_h   = 0;
    longint lag_out_h  = 0;

    logic [DATA_W-1:0] pending_drive [$];
    int                mismatches = 0;
    bit                idle_en = 1'b1;
    bit                hold_req = 1'b0;

    // Directed script: reset state, unity path, minus one gain, pole extremes
    row_t script [0:28] = '{
        '{ROW_WORD, REG_FFG, 32'h7FFFFFFF, 1'b1, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h80000000, 1'b1, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'hFFFFFFFF, 1'b1, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h00000001, 1'b1, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h00000000, 1'b1, 32'h00000000},
        '{ROW_CFG,  REG_FFG, 32'h00010000, 1'b0, 32'h00000000},
        '{ROW_CFG,  REG_FSG, 32'h00010000, 1'b0, 32'h00000000},
        '{ROW_CFG,  REG_OG,  32'h00010000, 1'b0, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
        '{ROW_WORD, REG_FFG, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
        '{ROW_WORD, REG_FFG, 32'h80000000, 1'b1, 32'hFFFFFFFF},
        '{ROW_WORD, REG_FFG, 32'h80000000, 1'b1, 32'h80000000},
        '{ROW_WORD, REG_FFG, 32'h00000000, 1'b1, 32'h80000000},
        '{ROW_WORD, REG_FFG, 32'h00010000, 1'b1, 32'h00010000},
        '{ROW_WORD, REG_FFG, 32'hFFFF0000, 1'b1, 32'h00000000},
        '{ROW_CFG,  REG_OG,  32'hFFFF0000, 1'b0, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h80000000, 1'b1, 32'h7FFFFFFF},
        '{ROW_WORD, REG_FFG, 32'h00000000, 1'b1, 32'h7FFFFFFF},
        '{ROW_CFG,  REG_IG,  32'h00010000, 1'b0, 32'h00000000},
        '{ROW_CFG,  REG_IPC, 32'hABC10000, 1'b0, 32'h00000000},
        '{ROW_CFG,  REG_FPC, 32'hFFFF0000, 1'b0, 32'h00000000},
        '{ROW_CFG,  REG_SPC, 32'h0001FFFF, 1'b0, 32'h00000000},
        '{ROW_CFG,  REG_FZC, 32'h80000000, 1'b0, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h12345678, 1'b0, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'hEDCBA988, 1'b0, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h7FFFFFFF, 1'b0, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h80000000, 1'b0, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'h00008000, 1'b0, 32'h00000000},
        '{ROW_WORD, REG_FFG, 32'hFFFF8000, 1'b0, 32'h00000000}
    };

    cascaded_iir_compensator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // Exact product, rounded half up to Q16.16
    function automatic longint q_product(longint a, longint b);
        longint p;
        p = a * b + 64'sd32768;
        return p >>> 16;
    endfunction

    // Advance the three sections by one sample and return the drive word
    function automatic logic [DATA_W-1:0] compensate(logic [DATA_W-1:0] word);
        longint x;
        longint v;
        longint s1;
        longint w;
        longint s2;
        longint u;
        longint d;
        x = longint'($signed(word));
        v = clamp_word(x - inj_in_h + q_product(coef[REG_IPC], inj_out_h));
        inj_in_h = x;
        inj_out_h = v;
        s1 = clamp_word(q_product(coef[REG_FFG], x) + q_product(coef[REG_IG], v));
        w = clamp_word(s1 + q_product(coef[REG_FZC], lead_in_h)
                          + q_product(coef[REG_FPC], lead_out_h));
        lead_in_h = s1;
        lead_out_h = w;
        s2 = clamp_word(q_product(coef[REG_FSG], w));
        u = clamp_word(s2 + lag_in_h + q_product(coef[REG_SPC], lag_out_h));
        lag_in_h = s2;
        lag_out_h = u;
        d = clamp_word(q_product(coef[REG_OG], u));
        return d[DATA_W-1:0];
    endfunction

    // Pick a coefficient word; pole registers carry junk above bit 17
    function automatic logic [DATA_W-1:0] pick_coef(reg_idx_t idx, coef_style_t style);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] junk;
        int                p;
        junk = $urandom();
        if (idx >= REG_FPC) begin
            case (style)
                SET_TAME: begin
                    p = int'($urandom_range(0, 131072)) - 65536;
                    word = p;
                end
                SET_WILD:
                    word = $urandom();
                default:
                    case ($urandom_range(4))
                        0: word = 32'h00010000;
                        1: word = 32'h00030000;
                        2: word = 32'h0001FFFF;
                        3: word = 32'h00020000;
                        default: word = 32'h00000000;
                    endcase
            endcase
            word = {junk[DATA_W-1:POLE_W], word[POLE_W-1:0]};
        end else begin
            case (style)
                SET_TAME: begin
                    if (idx == REG_FZC)
                        p = int'($urandom_range(0, 131072)) - 65536;
                    else
                        p = int'($urandom_range(0, 32'h30000)) - 32'sh18000;
                    word = p;
                end
                SET_WILD:
                    word = $urandom();
                default:
                    case ($urandom_range(4))
                        0: word = 32'h7FFFFFFF;
                        1: word = 32'h80000000;
                        2: word = 32'h00010000;
                        3: word = 32'hFFFF0000;
                        default: word = 32'h00000000;
                    endcase
            endcase
        end
        return word;
    endfunction

    // Mix of rail values, small signals and full-range words
    function automatic logic [DATA_W-1:0] pick_sample();
        int r;
        int s;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(3))
                0: return 32'h7FFFFFFF;
                1: return 32'h80000000;
                2: return 32'h00000000;
                default: return 32'hFFFFFFFF;
            endcase
        end
        if (r < 50) begin
            s = int'($urandom_range(0, 32'h80000)) - 32'sh40000;
            return s;
        end
        return $urandom();
    endfunction

    // Write one register, then drop the enable
    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        if (idx >= REG_FPC)
            coef[idx] = longint'($signed(data[POLE_W-1:0]));
        else
            coef[idx] = longint'($signed(data));
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one sample word, with random gaps, and log its expected drive
    task automatic offer_word(logic [DATA_W-1:0] word, logic typed,
                              logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] predicted;
        while (idle_en && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= word;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = compensate(word);
        pending_drive.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Hold the input idle until every expected drive word has come
    task automatic drain_words();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_drive.size() != 0);
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= idle_en && ($urandom_range(99) < 23);
            end
        end
    end

    // Compare each accepted drive word with the oldest expectation
    always @(posedge clk) begin
        logic [DATA_W-1:0] want;
        if (out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_drive.size() == 0) begin
                $error("drive: no word expected, got %h", drive);
                mismatches++;
            end else begin
                want = pending_drive.pop_front();
                if (drive !== want) begin
                    $error("drive: expected %h, got %h", want, drive);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        coef_style_t style;
        foreach (coef[i])
            coef[i] = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        in_valid = 1'b0;
        sample = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed script
        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                drain_words();
                write_reg(script[i].idx, script[i].value);
            end else begin
                offer_word(script[i].value, script[i].typed, script[i].want);
            end
        end

        // Random phases, each with a fresh coefficient set
        for (int p = 0; p < 6; p++) begin
            style = coef_style_t'(p % 3);
            drain_words();
            idle_en = (p != 3);
            for (int r = 0; r <= int'(REG_IPC); r++)
                write_reg(reg_idx_t'(r), pick_coef(reg_idx_t'(r), style));
            for (int n = 0; n < 75; n++) begin
                if (p == 1 && n == 20)
                    hold_req = 1'b1;
                if (p == 4 && n == 30)
                    drain_words();
                offer_word(pick_sample(), 1'b0, '0);
            end
        end

        // Let the last words come out, then report
        drain_words();
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[cascaded_iir_compensator.f]
rtl/cic_pkg.sv
rtl/cic_ucode_rom.sv
rtl/cic_datapath.sv
rtl/cascaded_iir_compensator.sv
sim/testbench.sv
